### rtl/b64le_pkg.sv
package b64le_pkg;

  localparam int LINE_CHARS_DEF = 76;
  localparam int LINE_W = 8;
  localparam int Q_DEPTH = 2;
  localparam int IDX_W = 3;

  localparam logic [7:0] CHAR_PAD = 8'h3D;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  localparam logic [IDX_W-1:0] IDX_LAST_GROUP = 3'd3;
  localparam logic [IDX_W-1:0] IDX_CR = 3'd4;
  localparam logic [IDX_W-1:0] IDX_LAST_CRLF = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic end_of_message;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic run_last;
    logic message_done;
  } out_beat_t;

  typedef struct packed {
    logic [3:0][7:0] chars;
    logic crlf;
    logic eom;
  } job_t;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

### rtl/base64_line_wrapped_encoder.sv
// Base64 encoder with line breaks after every LINE_CHARS characters of full groups.
// The input channel takes one message byte per beat, with end_of_message set on the
// final byte of a message. The output channel gives one ASCII character per beat.
// Bytes are held until a group of three is complete; that byte's beat then yields
// four characters, followed by CR LF when the line is full. The final byte of a
// message closes a partial group with '=' padding, which never counts toward the line.
// run_last marks the last character caused by an input byte, message_done the last
// character of the message.
// The first character of a group passes through the queue, the current-group
// register and the output register. Characters leave at one per cycle while groups
// are queued and the receiver is ready, so the output port sets the rate.
// A two-entry queue of encoded groups lets input continue while the receiver stalls;
// in_ready drops only when that queue is full, and no beat is lost or repeated.
// Synchronous reset clears the pending byte count, the line count, the queue, the
// current group and the output valid flag.
module base64_line_wrapped_encoder import b64le_pkg::*; #(
  parameter int LINE_CHARS = LINE_CHARS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_nonempty;
  job_t push_job;
  job_t head_job;

  b64le_front #(
    .LINE_CHARS(LINE_CHARS)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .q_full(q_full),
    .q_push(q_push),
    .q_job(push_job)
  );

  b64le_fifo u_fifo (
    .clk(clk),
    .rst_n(rst_n),
    .push(q_push),
    .push_job(push_job),
    .full(q_full),
    .pop(q_pop),
    .nonempty(q_nonempty),
    .head_job(head_job)
  );

  b64le_back u_back (
    .clk(clk),
    .rst_n(rst_n),
    .q_nonempty(q_nonempty),
    .q_job(head_job),
    .q_pop(q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

endmodule

### rtl/b64le_front.sv
module b64le_front import b64le_pkg::*; #(
  parameter int LINE_CHARS = LINE_CHARS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_beat_t in_data,
  input  logic     q_full,
  output logic     q_push,
  output job_t     q_job
);

  logic [7:0] first_r, first_nxt;
  logic [7:0] second_r, second_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic [LINE_W-1:0] line_sum;
  logic [7:0] bx, by, bz;
  logic [5:0] s0, s1, s2, s3;
  logic pad2, pad3;
  logic accept;
  logic produce;

  assign in_ready = !q_full;
  assign accept = in_valid && in_ready;
  assign line_sum = line_r + LINE_W'(4);

  always_comb begin
    first_nxt = first_r;
    second_nxt = second_r;
    cnt_nxt = cnt_r;
    line_nxt = line_r;
    produce = 1'b0;
    bx = first_r;
    by = second_r;
    bz = in_data.data_byte;
    pad2 = 1'b0;
    pad3 = 1'b0;
    q_job.crlf = 1'b0;
    q_job.eom = in_data.end_of_message;
    if (cnt_r == 2'd2) begin
      produce = 1'b1;
      cnt_nxt = 2'd0;
      if (line_sum >= LINE_W'(LINE_CHARS)) begin
        q_job.crlf = 1'b1;
        line_nxt = '0;
      end else begin
        line_nxt = line_sum;
      end
      if (in_data.end_of_message) begin
        line_nxt = '0;
      end
    end else if (!in_data.end_of_message) begin
      if (cnt_r == 2'd0) begin
        first_nxt = in_data.data_byte;
      end else begin
        second_nxt = in_data.data_byte;
      end
      cnt_nxt = cnt_r + 2'd1;
    end else if (cnt_r == 2'd0) begin
      produce = 1'b1;
      bx = in_data.data_byte;
      by = 8'h00;
      pad2 = 1'b1;
      pad3 = 1'b1;
      cnt_nxt = 2'd0;
      line_nxt = '0;
    end else begin
      produce = 1'b1;
      by = in_data.data_byte;
      bz = 8'h00;
      pad3 = 1'b1;
      cnt_nxt = 2'd0;
      line_nxt = '0;
    end
    s0 = bx[7:2];
    s1 = {bx[1:0], by[7:4]};
    s2 = {by[3:0], bz[7:6]};
    s3 = bz[5:0];
    q_job.chars[0] = b64_char(s0);
    q_job.chars[1] = b64_char(s1);
    q_job.chars[2] = pad2 ? CHAR_PAD : b64_char(s2);
    q_job.chars[3] = pad3 ? CHAR_PAD : b64_char(s3);
  end

  assign q_push = accept && produce;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      line_r <= '0;
    end else if (accept) begin
      cnt_r <= cnt_nxt;
      line_r <= line_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      first_r <= first_nxt;
      second_r <= second_nxt;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("pending count out of range");

  a_eom_clears: assert property (@(posedge clk) disable iff (!rst_n)
      accept && in_data.end_of_message |=> cnt_r == 2'd0 && line_r == '0)
    else $error("state not cleared after the last byte");

  a_line_below: assert property (@(posedge clk) disable iff (!rst_n)
      line_r < LINE_W'(LINE_CHARS))
    else $error("line count reached the line length");

endmodule

### rtl/b64le_fifo.sv
module b64le_fifo import b64le_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic nonempty,
  output job_t head_job
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  job_t mem_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full = cnt_r == CNT_W'(Q_DEPTH);
  assign nonempty = cnt_r != '0;
  assign head_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && !nonempty))
    else $error("pop from an empty queue");

endmodule

### rtl/b64le_back.sv
module b64le_back import b64le_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_nonempty,
  input  job_t      q_job,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  job_t cur_r;
  logic cur_vld_r;
  logic [IDX_W-1:0] idx_r;
  logic out_vld_r;
  out_beat_t out_r, out_nxt;
  logic slot_free;
  logic emit;
  logic is_last;

  assign slot_free = !out_vld_r || out_ready;
  assign emit = cur_vld_r && slot_free;
  assign is_last = idx_r == (cur_r.crlf ? IDX_LAST_CRLF : IDX_LAST_GROUP);
  assign q_pop = q_nonempty && (!cur_vld_r || (emit && is_last));

  always_comb begin
    out_nxt.run_last = is_last;
    out_nxt.message_done = is_last && cur_r.eom;
    case (idx_r)
      IDX_CR: out_nxt.out_char = CHAR_CR;
      IDX_LAST_CRLF: out_nxt.out_char = CHAR_LF;
      default: out_nxt.out_char = cur_r.chars[idx_r[1:0]];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      idx_r <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_vld_r <= 1'b1;
        idx_r <= '0;
      end else if (emit) begin
        if (is_last) begin
          cur_vld_r <= 1'b0;
          idx_r <= '0;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
      if (slot_free) begin
        out_vld_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_job;
    end
    if (emit) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data = out_r;

  a_idle_index: assert property (@(posedge clk) disable iff (!rst_n) !cur_vld_r |-> idx_r == '0)
    else $error("character index not at start while idle");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
      out_vld_r && out_r.message_done |-> out_r.run_last)
    else $error("message end not on the last beat of a byte");

endmodule
